FILE: rtl/core/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared widths, constants and the hue sector code for the converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned SPAN_W  = 8;   // 100 * (1 - |2L - 1|), at most 100
    localparam int unsigned DIST_W  = 6;   // distance term, at most 60
    localparam int unsigned PROD_W  = 14;  // span * sat, at most 10000
    localparam int unsigned NUM_W   = 21;  // numerators over 1200000
    localparam int unsigned SCL_W   = 18;  // numerator * 17 / 128
    localparam int unsigned QT_W    = 9;   // quotient estimate with headroom
    localparam int unsigned RECIP_W = 16;
    localparam int unsigned RECIP_SH = 25;

    localparam logic [HUE_W-1:0]  HUE_MAX  = 9'd360;
    localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
    localparam logic [NUM_W-1:0]  C_MULT   = 21'd120;
    localparam logic [NUM_W-1:0]  M_MULT   = 21'd60;
    localparam logic [NUM_W-1:0]  L_MULT   = 21'd12000;
    // floor(2^25 / 625): quotient estimate is never above the true one
    localparam logic [RECIP_W-1:0] RECIP_625 = 16'd53687;
    localparam logic [SCL_W-1:0]  DIV_625  = 18'd625;
    localparam logic [QT_W-1:0]   CHAN_SAT = 9'd255;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED,
        SEC_GREY
    } sector_t;

endpackage

FILE: rtl/core/hsl_to_rgb_converter.sv
// An accepted start passes down the pipeline to the done strobe with its result.
// Throughput: one transaction per cycle; busy stays low, six pipeline stages
// each carry a valid bit alongside the data.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset (rst_n low, asynchronous) clears the valid bits; data stages hold no
// reset value.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Pipelined integer conversion of hue/saturation/lightness to 8-bit RGB.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hsl_pkg::HUE_W-1:0]       hue_deg,
    input  logic [hsl_pkg::PCT_W-1:0]       sat_pct,
    input  logic [hsl_pkg::PCT_W-1:0]       light_pct,
    output logic                            done,
    output logic [hsl_pkg::CHAN_W-1:0]      red,
    output logic [hsl_pkg::CHAN_W-1:0]      green,
    output logic [hsl_pkg::CHAN_W-1:0]      blue,
    output logic                            in_range
);

    localparam int unsigned NCH = 3;

    // ---------------- stage 1: range check, sector, span, distance --------
    logic                          v1_reg;
    logic                          ok1_reg, ok1_next;
    hsl_pkg::sector_t              sec1_reg, sec1_next;
    logic [hsl_pkg::SPAN_W-1:0]    span1_reg, span1_next;
    logic [hsl_pkg::DIST_W-1:0]    dist1_reg, dist1_next;
    logic [hsl_pkg::PCT_W-1:0]     sat1_reg, sat1_next;
    logic [hsl_pkg::PCT_W-1:0]     lgt1_reg, lgt1_next;

    logic [hsl_pkg::HUE_W-1:0]     base;
    logic [hsl_pkg::HUE_W-1:0]     h120;
    logic [hsl_pkg::SPAN_W-1:0]    two_l;

    always_comb
    begin
        ok1_next = (hue_deg <= hsl_pkg::HUE_MAX) && (sat_pct <= hsl_pkg::PCT_MAX)
                   && (light_pct <= hsl_pkg::PCT_MAX);
        if (hue_deg < 9'd60)
        begin
            sec1_next = hsl_pkg::SEC_RED_YEL;  base = 9'd0;
        end
        else if (hue_deg < 9'd120)
        begin
            sec1_next = hsl_pkg::SEC_YEL_GRN;  base = 9'd0;
        end
        else if (hue_deg < 9'd180)
        begin
            sec1_next = hsl_pkg::SEC_GRN_CYN;  base = 9'd120;
        end
        else if (hue_deg < 9'd240)
        begin
            sec1_next = hsl_pkg::SEC_CYN_BLU;  base = 9'd120;
        end
        else if (hue_deg < 9'd300)
        begin
            sec1_next = hsl_pkg::SEC_BLU_MAG;  base = 9'd240;
        end
        else if (hue_deg < 9'd360)
        begin
            sec1_next = hsl_pkg::SEC_MAG_RED;  base = 9'd240;
        end
        else
        begin
            sec1_next = hsl_pkg::SEC_GREY;     base = 9'd360;
        end
        h120 = hue_deg - base;
        if (h120 < 9'd60)
            dist1_next = h120[hsl_pkg::DIST_W-1:0];
        else
            dist1_next = 6'((9'd120 - h120) & 9'h3F);
        two_l = {light_pct, 1'b0};
        span1_next = (two_l >= 8'd100) ? (8'd200 - two_l) : two_l;
        sat1_next  = sat_pct;
        lgt1_next  = light_pct;
        // zero operands make every channel come out zero on invalid input
        if (!ok1_next)
        begin
            span1_next = '0;
            dist1_next = '0;
            sat1_next  = '0;
            lgt1_next  = '0;
            sec1_next  = hsl_pkg::SEC_GREY;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg   <= ok1_next;
        sec1_reg  <= sec1_next;
        span1_reg <= span1_next;
        dist1_reg <= dist1_next;
        sat1_reg  <= sat1_next;
        lgt1_reg  <= lgt1_next;
    end

    // ---------------- stage 2: span * saturation ---------------------------
    logic                          v2_reg;
    logic                          ok2_reg;
    hsl_pkg::sector_t              sec2_reg;
    logic [hsl_pkg::DIST_W-1:0]    dist2_reg;
    logic [hsl_pkg::PCT_W-1:0]     lgt2_reg;
    logic [hsl_pkg::PROD_W-1:0]    ps2_reg, ps2_next;

    assign ps2_next = hsl_pkg::PROD_W'(span1_reg) * hsl_pkg::PROD_W'(sat1_reg);

    always_ff @(posedge clk)
    begin
        ok2_reg   <= ok1_reg;
        sec2_reg  <= sec1_reg;
        dist2_reg <= dist1_reg;
        lgt2_reg  <= lgt1_reg;
        ps2_reg   <= ps2_next;
    end

    // ---------------- stage 3: C, X and m numerators -----------------------
    logic                          v3_reg;
    logic                          ok3_reg;
    hsl_pkg::sector_t              sec3_reg;
    logic [hsl_pkg::NUM_W-1:0]     cn3_reg, cn3_next;
    logic [hsl_pkg::NUM_W-1:0]     xn3_reg, xn3_next;
    logic [hsl_pkg::NUM_W-1:0]     mn3_reg, mn3_next;

    always_comb
    begin
        cn3_next = hsl_pkg::NUM_W'(ps2_reg) * hsl_pkg::C_MULT;
        xn3_next = hsl_pkg::NUM_W'({ps2_reg, 1'b0}) * hsl_pkg::NUM_W'(dist2_reg);
        mn3_next = hsl_pkg::NUM_W'(lgt2_reg) * hsl_pkg::L_MULT
                   - hsl_pkg::NUM_W'(ps2_reg) * hsl_pkg::M_MULT;
    end

    always_ff @(posedge clk)
    begin
        ok3_reg  <= ok2_reg;
        sec3_reg <= sec2_reg;
        cn3_reg  <= cn3_next;
        xn3_reg  <= xn3_next;
        mn3_reg  <= mn3_next;
    end

    // ---------------- stage 4: sector select, scale by 17/128 --------------
    logic                          v4_reg;
    logic                          ok4_reg;
    logic [hsl_pkg::NUM_W-1:0]     cm, xm;
    logic [hsl_pkg::NUM_W-1:0]     num4 [NCH];
    logic [hsl_pkg::NUM_W+4:0]     x17  [NCH];
    logic [hsl_pkg::SCL_W-1:0]     y4_reg [NCH];
    logic [hsl_pkg::SCL_W-1:0]     y4_next [NCH];

    always_comb
    begin
        cm = cn3_reg + mn3_reg;
        xm = xn3_reg + mn3_reg;
        unique case (sec3_reg)
            hsl_pkg::SEC_RED_YEL:
            begin
                num4[0] = cm;      num4[1] = xm;      num4[2] = mn3_reg;
            end
            hsl_pkg::SEC_YEL_GRN:
            begin
                num4[0] = xm;      num4[1] = cm;      num4[2] = mn3_reg;
            end
            hsl_pkg::SEC_GRN_CYN:
            begin
                num4[0] = mn3_reg; num4[1] = cm;      num4[2] = xm;
            end
            hsl_pkg::SEC_CYN_BLU:
            begin
                num4[0] = mn3_reg; num4[1] = xm;      num4[2] = cm;
            end
            hsl_pkg::SEC_BLU_MAG:
            begin
                num4[0] = xm;      num4[1] = mn3_reg; num4[2] = cm;
            end
            hsl_pkg::SEC_MAG_RED:
            begin
                num4[0] = cm;      num4[1] = mn3_reg; num4[2] = xm;
            end
            hsl_pkg::SEC_GREY:
            begin
                num4[0] = mn3_reg; num4[1] = mn3_reg; num4[2] = mn3_reg;
            end
            default:
            begin
                num4[0] = mn3_reg; num4[1] = mn3_reg; num4[2] = mn3_reg;
            end
        endcase
        // num * 255 / 1200000 == (num * 17 / 128) / 625
        for (int i = 0; i < NCH; i++)
        begin
            x17[i]     = {1'b0, num4[i], 4'b0} + {5'b0, num4[i]};
            y4_next[i] = x17[i][hsl_pkg::SCL_W+6:7];
        end
    end

    always_ff @(posedge clk)
    begin
        ok4_reg <= ok3_reg;
        for (int i = 0; i < NCH; i++)
            y4_reg[i] <= y4_next[i];
    end

    // ---------------- stage 5: quotient estimate by reciprocal -------------
    localparam int unsigned PQ_W = hsl_pkg::SCL_W + hsl_pkg::RECIP_W;

    logic                          v5_reg;
    logic                          ok5_reg;
    logic [PQ_W-1:0]               pq5 [NCH];
    logic [hsl_pkg::SCL_W-1:0]     y5_reg [NCH];
    logic [hsl_pkg::QT_W-1:0]      q5_reg [NCH];
    logic [hsl_pkg::QT_W-1:0]      q5_next [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            pq5[i]     = PQ_W'(y4_reg[i]) * PQ_W'(hsl_pkg::RECIP_625);
            q5_next[i] = pq5[i][hsl_pkg::RECIP_SH +: hsl_pkg::QT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        ok5_reg <= ok4_reg;
        for (int i = 0; i < NCH; i++)
        begin
            y5_reg[i] <= y4_reg[i];
            q5_reg[i] <= q5_next[i];
        end
    end

    // ---------------- stage 6: correct by one, saturate, output ------------
    logic                          v6_reg;
    logic                          ok6_reg;
    logic [hsl_pkg::SCL_W-1:0]     rem6 [NCH];
    logic [hsl_pkg::QT_W-1:0]      qc6  [NCH];
    logic [hsl_pkg::CHAN_W-1:0]    ch6_reg [NCH];
    logic [hsl_pkg::CHAN_W-1:0]    ch6_next [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            rem6[i] = y5_reg[i] - hsl_pkg::SCL_W'(q5_reg[i]) * hsl_pkg::DIV_625;
            qc6[i]  = (rem6[i] >= hsl_pkg::DIV_625) ? q5_reg[i] + 9'd1 : q5_reg[i];
            if (qc6[i] > hsl_pkg::CHAN_SAT)
                qc6[i] = hsl_pkg::CHAN_SAT;
            ch6_next[i] = ok5_reg ? qc6[i][hsl_pkg::CHAN_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        ok6_reg <= ok5_reg;
        for (int i = 0; i < NCH; i++)
            ch6_reg[i] <= ch6_next[i];
    end

    // ---------------- valid bits -------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign busy     = 1'b0;
    assign done     = v6_reg;
    assign red      = ch6_reg[0];
    assign green    = ch6_reg[1];
    assign blue     = ch6_reg[2];
    assign in_range = ok6_reg;

    // ---------------- assertions -------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##6 done)
        else $error("accepted transaction did not complete after six cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##6 !done)
        else $error("done strobe without an accepted transaction");

    a_bad_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (start && hue_deg > hsl_pkg::HUE_MAX) |-> ##6 (done && !in_range))
        else $error("hue out of range not flagged");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (red == '0 && green == '0 && blue == '0))
        else $error("invalid transaction produced nonzero color");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && hue_deg == hsl_pkg::HUE_MAX && sat_pct <= hsl_pkg::PCT_MAX
         && light_pct <= hsl_pkg::PCT_MAX) |-> ##6 (red == green && green == blue))
        else $error("hue 360 did not produce grey");

endmodule
